[hdl/setpoint_guard_watchdog_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the setpoint guard
// Clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef SETPOINT_GUARD_WATCHDOG_ASSERT_SVH
`define SETPOINT_GUARD_WATCHDOG_ASSERT_SVH

// same-cycle implication
`define SGW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("setpoint guard check failed");

// next-cycle implication
`define SGW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("setpoint guard check failed");

`endif

[hdl/sgw_pkg.sv]
// ----------------------------------------------------------------------------
// Setpoint guard package
// Widths, codes and reset values shared by the guard and its channels.
// ----------------------------------------------------------------------------
package sgw_pkg;

	localparam int JOINT_COUNT = 6;
	localparam int PORT_JOINTS = 6;
	localparam int ANGLE_WIDTH = 24;
	localparam int LIMIT_W     = 23;
	localparam int TIMEOUT_W   = 16;
	localparam int SILENCE_W   = 17;
	localparam int JOINT_IDX_W = 3;
	localparam int DIFF_W      = ANGLE_WIDTH + 1;
	localparam int CMP_W       = (DIFF_W > LIMIT_W) ? DIFF_W : LIMIT_W;

	typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
	typedef logic        [LIMIT_W-1:0]     limit_t;
	typedef logic        [TIMEOUT_W-1:0]   timeout_t;
	typedef logic        [SILENCE_W-1:0]   silence_t;
	typedef logic        [1:0]             cmd_t;
	typedef logic        [1:0]             reg_idx_t;

	localparam cmd_t CMD_TICK    = 2'd0;
	localparam cmd_t CMD_FRAME   = 2'd1;
	localparam cmd_t CMD_ENCODER = 2'd2;

	localparam reg_idx_t REG_RANGE_LIMIT = 2'd0;
	localparam reg_idx_t REG_STEP_LIMIT  = 2'd1;
	localparam reg_idx_t REG_TIMEOUT_MS  = 2'd2;

	localparam limit_t   RANGE_LIMIT_RST = LIMIT_W'(72000);
	localparam limit_t   STEP_LIMIT_RST  = LIMIT_W'(3000);
	localparam timeout_t TIMEOUT_MS_RST  = TIMEOUT_W'(1000);
	localparam silence_t SILENCE_MAX     = '1;

	typedef enum logic [2:0] {
		STAT_NONE      = 3'd0,
		STAT_ACCEPT    = 3'd1,
		STAT_ACCEPT_EN = 3'd2,
		STAT_RANGE     = 3'd3,
		STAT_STEP      = 3'd4,
		STAT_TIMEOUT   = 3'd5
	} status_t;

endpackage

[hdl/sgw_in_if.sv]
// ----------------------------------------------------------------------------
// Setpoint guard input channel
// Valid/ready channel carrying one command, frame or encoder word.
// ----------------------------------------------------------------------------
interface sgw_in_if;
	logic           valid;
	logic           ready;
	sgw_pkg::cmd_t   command;
	sgw_pkg::angle_t angle_one;
	sgw_pkg::angle_t angle_two;
	sgw_pkg::angle_t angle_three;
	sgw_pkg::angle_t angle_four;
	sgw_pkg::angle_t angle_five;
	sgw_pkg::angle_t angle_six;

	modport source (
		output valid, command, angle_one, angle_two, angle_three,
		angle_four, angle_five, angle_six,
		input  ready
	);
	modport sink (
		input  valid, command, angle_one, angle_two, angle_three,
		angle_four, angle_five, angle_six,
		output ready
	);
endinterface

[hdl/sgw_out_if.sv]
// ----------------------------------------------------------------------------
// Setpoint guard result channel
// Valid/ready channel carrying status and held targets for one word.
// ----------------------------------------------------------------------------
interface sgw_out_if;
	logic            valid;
	logic            ready;
	logic [2:0]      status;
	logic [2:0]      failing_joint;
	logic            enabled;
	sgw_pkg::angle_t target_one;
	sgw_pkg::angle_t target_two;
	sgw_pkg::angle_t target_three;
	sgw_pkg::angle_t target_four;
	sgw_pkg::angle_t target_five;
	sgw_pkg::angle_t target_six;

	modport source (
		output valid, status, failing_joint, enabled, target_one, target_two,
		target_three, target_four, target_five, target_six,
		input  ready
	);
	modport sink (
		input  valid, status, failing_joint, enabled, target_one, target_two,
		target_three, target_four, target_five, target_six,
		output ready
	);
endinterface

[hdl/setpoint_guard_watchdog.sv]
// A word taken by the input register moves on into the result register
// when the result side is not stalled.
// Throughput: one word per cycle; while a result waits the input register takes
// one more word, then input stalls until the result word is taken.
// Reset (arst_n low, asynchronous): limits return to their defaults, targets
// and encoder angles clear, guard off, silence count zero, both stages empty.
// ----------------------------------------------------------------------------
// Setpoint guard watchdog
// Range and step checks on six joint setpoints with a silence timeout.
// ----------------------------------------------------------------------------
module setpoint_guard_watchdog (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  sgw_pkg::reg_idx_t    wr_index,
	input  sgw_pkg::limit_t      wr_data,
	sgw_in_if.sink               in_ch,
	sgw_out_if.source            out_ch
);

	localparam int JC = sgw_pkg::JOINT_COUNT;
	localparam int PJ = sgw_pkg::PORT_JOINTS;
	localparam int AW = sgw_pkg::ANGLE_WIDTH;
	localparam int DW = sgw_pkg::DIFF_W;
	localparam int CW = sgw_pkg::CMP_W;

	sgw_pkg::limit_t   range_limit_q;
	sgw_pkg::limit_t   step_limit_q;
	sgw_pkg::timeout_t timeout_q;

	sgw_pkg::angle_t   ang_in [PJ];
	logic              valid_s1;
	sgw_pkg::cmd_t     cmd_s1;
	sgw_pkg::angle_t   ang_s1 [JC];

	sgw_pkg::angle_t   targets_q [PJ];
	sgw_pkg::angle_t   meas_q [JC];
	logic              guard_q;
	sgw_pkg::silence_t silence_q;

	sgw_pkg::angle_t   targets_n [PJ];
	sgw_pkg::angle_t   meas_n [JC];
	logic              guard_n;
	sgw_pkg::silence_t silence_n;
	sgw_pkg::silence_t silence_inc;
	sgw_pkg::status_t  status_n;
	logic [2:0]        fail_n;
	logic              fail_found;
	logic [DW-1:0]     ang_ext [JC];
	logic [DW-1:0]     diff [JC];
	logic [DW-1:0]     abs_ang [JC];
	logic [DW-1:0]     abs_step [JC];
	logic              range_bad [JC];
	logic              step_bad [JC];

	logic              out_valid_q;
	sgw_pkg::status_t  status_s2;
	logic [2:0]        fail_s2;
	logic              enabled_s2;
	sgw_pkg::angle_t   targets_s2 [PJ];

	logic              advance;
	logic              take;

	assign ang_in[0] = in_ch.angle_one;
	assign ang_in[1] = in_ch.angle_two;
	assign ang_in[2] = in_ch.angle_three;
	assign ang_in[3] = in_ch.angle_four;
	assign ang_in[4] = in_ch.angle_five;
	assign ang_in[5] = in_ch.angle_six;

	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_limit_q <= sgw_pkg::RANGE_LIMIT_RST;
			step_limit_q  <= sgw_pkg::STEP_LIMIT_RST;
			timeout_q     <= sgw_pkg::TIMEOUT_MS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				sgw_pkg::REG_RANGE_LIMIT: range_limit_q <= wr_data;
				sgw_pkg::REG_STEP_LIMIT:  step_limit_q  <= wr_data;
				sgw_pkg::REG_TIMEOUT_MS:  timeout_q     <= wr_data[sgw_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= in_ch.command;
			for (int j = 0; j < JC; j++) begin
				ang_s1[j] <= ang_in[j];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < JC; j++) begin
			ang_ext[j]   = {ang_s1[j][AW-1], ang_s1[j]};
			diff[j]      = ang_ext[j] - {targets_q[j][AW-1], targets_q[j]};
			abs_ang[j]   = ang_ext[j][DW-1] ? (~ang_ext[j] + 1'b1) : ang_ext[j];
			abs_step[j]  = diff[j][DW-1] ? (~diff[j] + 1'b1) : diff[j];
			range_bad[j] = CW'(abs_ang[j]) > CW'(range_limit_q);
			step_bad[j]  = CW'(abs_step[j]) > CW'(step_limit_q);
		end
	end

	always_comb begin
		targets_n   = targets_q;
		meas_n      = meas_q;
		guard_n     = guard_q;
		silence_n   = silence_q;
		status_n    = sgw_pkg::STAT_NONE;
		fail_n      = '0;
		fail_found  = 1'b0;
		silence_inc = (silence_q == sgw_pkg::SILENCE_MAX) ? silence_q : silence_q + 1'b1;
		case (cmd_s1)
			sgw_pkg::CMD_TICK: begin
				silence_n = silence_inc;
				if (guard_q && (silence_inc > sgw_pkg::SILENCE_W'(timeout_q))) begin
					guard_n  = 1'b0;
					status_n = sgw_pkg::STAT_TIMEOUT;
				end
			end
			sgw_pkg::CMD_FRAME: begin
				for (int j = 0; j < JC; j++) begin
					if (!fail_found) begin
						if (range_bad[j]) begin
							fail_found = 1'b1;
							status_n   = sgw_pkg::STAT_RANGE;
							fail_n     = 3'(j);
						end else if (guard_q && step_bad[j]) begin
							fail_found = 1'b1;
							status_n   = sgw_pkg::STAT_STEP;
							fail_n     = 3'(j);
						end
					end
				end
				if (!fail_found) begin
					silence_n = '0;
					if (guard_q) begin
						for (int j = 0; j < JC; j++) begin
							targets_n[j] = ang_s1[j];
						end
						status_n = sgw_pkg::STAT_ACCEPT;
					end else begin
						for (int j = 0; j < JC; j++) begin
							targets_n[j] = meas_q[j];
						end
						guard_n  = 1'b1;
						status_n = sgw_pkg::STAT_ACCEPT_EN;
					end
				end
			end
			sgw_pkg::CMD_ENCODER: begin
				for (int j = 0; j < JC; j++) begin
					meas_n[j] = ang_s1[j];
				end
			end
			default: ;
		endcase
	end

	// guard state, updated as the word moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q   <= 1'b0;
			silence_q <= '0;
			for (int j = 0; j < PJ; j++) begin
				targets_q[j] <= '0;
			end
			for (int j = 0; j < JC; j++) begin
				meas_q[j] <= '0;
			end
		end else if (valid_s1 && advance) begin
			guard_q   <= guard_n;
			silence_q <= silence_n;
			targets_q <= targets_n;
			meas_q    <= meas_n;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			status_s2  <= status_n;
			fail_s2    <= fail_n;
			enabled_s2 <= guard_n;
			targets_s2 <= targets_n;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = status_s2;
	assign out_ch.failing_joint = fail_s2;
	assign out_ch.enabled       = enabled_s2;
	assign out_ch.target_one    = targets_s2[0];
	assign out_ch.target_two    = targets_s2[1];
	assign out_ch.target_three  = targets_s2[2];
	assign out_ch.target_four   = targets_s2[3];
	assign out_ch.target_five   = targets_s2[4];
	assign out_ch.target_six    = targets_s2[5];

endmodule

[hdl/sgw_checker.sv]
// ----------------------------------------------------------------------------
// Setpoint guard result checker
// Port-level checks on result words, bound to the guard top level.
// ----------------------------------------------------------------------------
`include "setpoint_guard_watchdog_assert.svh"

module sgw_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input logic [2:0]      status,
	input logic [2:0]      failing_joint,
	input logic            enabled,
	input sgw_pkg::angle_t target_one
);

	`SGW_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(failing_joint) && $stable(enabled) && $stable(target_one))

	`SGW_ASSERT_IMPLY(a_joint_only_on_reject, clk, arst_n, out_valid && status != sgw_pkg::STAT_RANGE && status != sgw_pkg::STAT_STEP, failing_joint == 3'd0)

	`SGW_ASSERT_IMPLY(a_accept_enables, clk, arst_n, out_valid && (status == sgw_pkg::STAT_ACCEPT || status == sgw_pkg::STAT_ACCEPT_EN), enabled)

	`SGW_ASSERT_IMPLY(a_timeout_disables, clk, arst_n, out_valid && status == sgw_pkg::STAT_TIMEOUT, !enabled)

endmodule

bind setpoint_guard_watchdog sgw_checker u_sgw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.status        (out_ch.status),
	.failing_joint (out_ch.failing_joint),
	.enabled       (out_ch.enabled),
	.target_one    (out_ch.target_one)
);
